// File: sv/bdr_pkg.sv
// shared types and constants for the button debounce, repeat and key fifo block
package bdr_pkg;

	localparam int NUM_BTN  = 4;
	localparam int CODE_W   = 8;
	localparam int FILTER_W = 7;
	localparam int CNT_W    = 8;
	localparam int LONG_W   = 10;
	localparam int REP_W    = 8;
	localparam int CFG_IW   = 3;
	localparam int CFG_DW   = 10;

	localparam logic [FILTER_W-1:0] FILTER_RST = 7'd5;
	localparam logic [LONG_W-1:0]   LONG_RST   = 10'd100;
	localparam logic [REP_W-1:0]    PERIOD_RST = 8'd10;
	localparam logic [NUM_BTN-1:0]  ENABLE_RST = 4'd3;
	localparam logic [CNT_W-1:0]    DEB_RST    = 8'd2;
	localparam logic [CODE_W-1:0]   CODE_UP_RST    = 8'd1;
	localparam logic [CODE_W-1:0]   CODE_DOWN_RST  = 8'd2;
	localparam logic [CODE_W-1:0]   CODE_LEFT_RST  = 8'd3;
	localparam logic [CODE_W-1:0]   CODE_RIGHT_RST = 8'd4;

	typedef enum logic [CFG_IW-1:0] {
		CFG_FILTER     = 3'd0,
		CFG_LONG       = 3'd1,
		CFG_PERIOD     = 3'd2,
		CFG_ENABLE     = 3'd3,
		CFG_CODE_UP    = 3'd4,
		CFG_CODE_DOWN  = 3'd5,
		CFG_CODE_LEFT  = 3'd6,
		CFG_CODE_RIGHT = 3'd7
	} cfg_idx_t;

	typedef enum logic {
		KIND_TICK = 1'b0,
		KIND_READ = 1'b1
	} kind_t;

	typedef struct packed {
		logic [FILTER_W-1:0] filter;
		logic [LONG_W-1:0]   long_time;
		logic [REP_W-1:0]    period;
	} lane_cfg_t;

	typedef struct packed {
		logic [NUM_BTN-1:0]             v;
		logic [NUM_BTN-1:0][CODE_W-1:0] code;
	} push_req_t;

endpackage

// File: sv/bdr_lane.sv
// one button lane: integrating debounce, long-press and repeat counters
module bdr_lane (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     go,
	input  logic                     down,
	input  logic                     rep_en,
	input  bdr_pkg::lane_cfg_t       cfg,
	output logic                     push
);

	logic [bdr_pkg::CNT_W-1:0]  cnt_q, cnt_d;
	logic                       held_q, held_d;
	logic [bdr_pkg::LONG_W-1:0] long_q, long_d;
	logic [bdr_pkg::REP_W-1:0]  rep_q, rep_d;
	logic [bdr_pkg::CNT_W-1:0]  ft, top;
	logic [bdr_pkg::REP_W-1:0]  rep_inc;

	assign ft      = {1'b0, cfg.filter};
	assign top     = {cfg.filter, 1'b0};
	assign rep_inc = rep_q + 1'b1;

	always_comb begin
		cnt_d  = cnt_q;
		held_d = held_q;
		long_d = long_q;
		rep_d  = rep_q;
		push   = 1'b0;
		if (down) begin
			if (cnt_q < ft) begin
				cnt_d = ft;
			end else if (cnt_q < top) begin
				cnt_d = cnt_q + 1'b1;
			end else begin
				if (!held_q) begin
					held_d = 1'b1;
					push   = 1'b1;
				end
				if (cfg.long_time != '0) begin
					if (long_q < cfg.long_time) begin
						long_d = long_q + 1'b1;
					end else if (cfg.period != '0 && rep_en) begin
						if (rep_inc >= cfg.period) begin
							rep_d = '0;
							push  = 1'b1;
						end else begin
							rep_d = rep_inc;
						end
					end
				end
			end
		end else begin
			if (cnt_q > ft) begin
				cnt_d = ft;
			end else if (cnt_q != '0) begin
				cnt_d = cnt_q - 1'b1;
			end else begin
				held_d = 1'b0;
			end
			long_d = '0;
			rep_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= bdr_pkg::DEB_RST;
			held_q <= 1'b0;
			long_q <= '0;
			rep_q  <= '0;
		end else if (go) begin
			cnt_q  <= cnt_d;
			held_q <= held_d;
			long_q <= long_d;
			rep_q  <= rep_d;
		end
	end

endmodule

// File: sv/bdr_fifo.sv
// key code ring fifo with push staging and registered pop read
module bdr_fifo #(
	parameter int FIFO_DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  bdr_pkg::push_req_t          req,
	output logic                        busy,
	input  logic                        pop,
	output logic [bdr_pkg::CODE_W-1:0]  rd_code
);

	localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

	logic [bdr_pkg::CODE_W-1:0] mem [FIFO_DEPTH];
	logic [bdr_pkg::CODE_W-1:0] mem_rd_q;
	logic                       empty_q;
	logic [AW-1:0]              rd_q, wr_q;
	logic [bdr_pkg::NUM_BTN-1:0]                     pend_q;
	logic [bdr_pkg::NUM_BTN-1:0][bdr_pkg::CODE_W-1:0] pend_code_q;
	logic [1:0]                 sel;
	logic                       empty;

	assign busy    = |pend_q;
	assign empty   = (rd_q == wr_q);
	assign rd_code = empty_q ? '0 : mem_rd_q;

	// lowest pending button goes first
	always_comb begin
		sel = '0;
		for (int i = bdr_pkg::NUM_BTN - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				sel = 2'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			rd_q   <= '0;
			wr_q   <= '0;
		end else begin
			if (load) begin
				pend_q <= req.v;
			end else if (busy) begin
				pend_q[sel] <= 1'b0;
				wr_q <= (wr_q == AW'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_q <= (rd_q == AW'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pend_code_q <= req.code;
		end
		if (busy) begin
			mem[wr_q] <= pend_code_q[sel];
		end
		if (pop) begin
			mem_rd_q <= mem[rd_q];
			empty_q  <= empty;
		end
	end

endmodule

// File: sv/button_debounce_repeat_fifo.sv
// top level: four-button debounce with auto-repeat feeding a key code fifo
//
//  channel | handshake              | payload
//  --------+------------------------+----------------------------
//  in      | in_valid / in_stall    | kind, pressed
//  out     | out_valid / out_stall  | key_code
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// an item is registered, then worked once it is not stalled; a read result is
// written into the output register as its item is worked
// a tick that pushes codes holds the input while the single
// fifo write port drains them; otherwise one item per cycle
// a read waits while the output register is full and stalled
// reset presets counters and clears pointers; fifo contents are not cleared
module button_debounce_repeat_fifo #(
	parameter int FIFO_DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          kind,
	input  logic [bdr_pkg::NUM_BTN-1:0]   pressed,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bdr_pkg::CODE_W-1:0]    key_code,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bdr_pkg::CFG_IW-1:0]    cfg_index,
	input  logic [bdr_pkg::CFG_DW-1:0]    cfg_data
);

	logic [bdr_pkg::FILTER_W-1:0]                    filter_q;
	logic [bdr_pkg::LONG_W-1:0]                      long_q;
	logic [bdr_pkg::REP_W-1:0]                       period_q;
	logic [bdr_pkg::NUM_BTN-1:0]                     enable_q;
	logic [bdr_pkg::NUM_BTN-1:0][bdr_pkg::CODE_W-1:0] code_q;

	logic                        valid_s1;
	logic                        kind_s1;
	logic [bdr_pkg::NUM_BTN-1:0] pressed_s1;
	logic                        out_valid_q;
	logic                        busy, out_free, go_s1, tick_go, read_go, accept;
	logic [bdr_pkg::NUM_BTN-1:0] lane_push;
	bdr_pkg::lane_cfg_t          lane_cfg;
	bdr_pkg::push_req_t          req;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_q <= bdr_pkg::FILTER_RST;
			long_q   <= bdr_pkg::LONG_RST;
			period_q <= bdr_pkg::PERIOD_RST;
			enable_q <= bdr_pkg::ENABLE_RST;
			code_q[0] <= bdr_pkg::CODE_UP_RST;
			code_q[1] <= bdr_pkg::CODE_DOWN_RST;
			code_q[2] <= bdr_pkg::CODE_LEFT_RST;
			code_q[3] <= bdr_pkg::CODE_RIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (bdr_pkg::cfg_idx_t'(cfg_index))
				bdr_pkg::CFG_FILTER:     filter_q  <= cfg_data[bdr_pkg::FILTER_W-1:0];
				bdr_pkg::CFG_LONG:       long_q    <= cfg_data[bdr_pkg::LONG_W-1:0];
				bdr_pkg::CFG_PERIOD:     period_q  <= cfg_data[bdr_pkg::REP_W-1:0];
				bdr_pkg::CFG_ENABLE:     enable_q  <= cfg_data[bdr_pkg::NUM_BTN-1:0];
				bdr_pkg::CFG_CODE_UP:    code_q[0] <= cfg_data[bdr_pkg::CODE_W-1:0];
				bdr_pkg::CFG_CODE_DOWN:  code_q[1] <= cfg_data[bdr_pkg::CODE_W-1:0];
				bdr_pkg::CFG_CODE_LEFT:  code_q[2] <= cfg_data[bdr_pkg::CODE_W-1:0];
				bdr_pkg::CFG_CODE_RIGHT: code_q[3] <= cfg_data[bdr_pkg::CODE_W-1:0];
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign go_s1    = valid_s1 && !busy &&
	                  (kind_s1 == bdr_pkg::KIND_TICK || out_free);
	assign tick_go  = go_s1 && kind_s1 == bdr_pkg::KIND_TICK;
	assign read_go  = go_s1 && kind_s1 == bdr_pkg::KIND_READ;
	assign in_stall = valid_s1 && !go_s1;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (go_s1) begin
				valid_s1 <= 1'b0;
			end
			if (read_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1    <= kind;
			pressed_s1 <= pressed;
		end
	end

	assign lane_cfg.filter    = filter_q;
	assign lane_cfg.long_time = long_q;
	assign lane_cfg.period    = period_q;

	for (genvar b = 0; b < bdr_pkg::NUM_BTN; b++) begin : g_lane
		bdr_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.go     (tick_go),
			.down   (pressed_s1[b]),
			.rep_en (enable_q[b]),
			.cfg    (lane_cfg),
			.push   (lane_push[b])
		);
		assign req.v[b]    = lane_push[b] && code_q[b] != '0;
		assign req.code[b] = code_q[b];
	end

	bdr_fifo #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (tick_go),
		.req     (req),
		.busy    (busy),
		.pop     (read_go),
		.rd_code (key_code)
	);

	assign out_valid = out_valid_q;

endmodule

// File: sv/bdr_check.sv
// port-level checker for the debounce block, bound to the top level
module bdr_check (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic                        kind,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [bdr_pkg::CODE_W-1:0]  key_code,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready
);

	logic [2:0] open_q;
	logic       rd_in, rd_out;

	assign rd_in  = in_valid && !in_stall && kind == bdr_pkg::KIND_READ;
	assign rd_out = out_valid && !out_stall;

	// reads taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else begin
			open_q <= open_q + {2'b0, rd_in} - {2'b0, rd_out};
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(key_code))
		else $error("result changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> open_q != 3'd0)
		else $error("result without a read item");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= 3'd2)
		else $error("too many reads in flight");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write refused");

endmodule

bind button_debounce_repeat_fifo bdr_check u_bdr_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.kind      (kind),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.key_code  (key_code),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

// File: tb/key_code_checker.sv
// key code checker: watches all three channels, tracks the debounce lanes and key fifo, compares
`timescale 1ns / 1ps
module key_code_checker #(
	parameter int DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic                         kind,
	input  logic [bdr_pkg::NUM_BTN-1:0]  pressed,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [bdr_pkg::CODE_W-1:0]   key_code,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [bdr_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [bdr_pkg::CFG_DW-1:0]   cfg_data,
	output int                           errors,
	output int                           pending,
	output int                           codes_checked,
	output int                           codes_nonzero
);

	localparam int AW = $clog2(DEPTH);

	logic [bdr_pkg::FILTER_W-1:0] filt;
	logic [bdr_pkg::LONG_W-1:0]   long_lim;
	logic [bdr_pkg::REP_W-1:0]    period;
	logic [bdr_pkg::NUM_BTN-1:0]  rep_en;
	logic [bdr_pkg::CODE_W-1:0]   btn_code [bdr_pkg::NUM_BTN];

	logic [bdr_pkg::CNT_W-1:0]    deb [bdr_pkg::NUM_BTN];
	logic                         held [bdr_pkg::NUM_BTN];
	logic [bdr_pkg::LONG_W-1:0]   long_cnt [bdr_pkg::NUM_BTN];
	logic [bdr_pkg::REP_W-1:0]    rep_cnt [bdr_pkg::NUM_BTN];
	logic [bdr_pkg::CODE_W-1:0]   key_fifo [DEPTH];
	logic [AW-1:0]                rd_ptr;
	logic [AW-1:0]                wr_ptr;

	logic [bdr_pkg::CODE_W-1:0]   popped_codes [$];
	logic [bdr_pkg::CODE_W-1:0]   want;
	int                           deb_top;

	task automatic push_code(input logic [bdr_pkg::CODE_W-1:0] c);
		if (c != '0) begin
			key_fifo[wr_ptr] = c;
			wr_ptr = (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt = bdr_pkg::FILTER_RST;
			long_lim = bdr_pkg::LONG_RST;
			period = bdr_pkg::PERIOD_RST;
			rep_en = bdr_pkg::ENABLE_RST;
			btn_code[0] = bdr_pkg::CODE_UP_RST;
			btn_code[1] = bdr_pkg::CODE_DOWN_RST;
			btn_code[2] = bdr_pkg::CODE_LEFT_RST;
			btn_code[3] = bdr_pkg::CODE_RIGHT_RST;
			for (int b = 0; b < bdr_pkg::NUM_BTN; b++) begin
				deb[b] = bdr_pkg::DEB_RST;
				held[b] = 1'b0;
				long_cnt[b] = '0;
				rep_cnt[b] = '0;
			end
			rd_ptr = '0;
			wr_ptr = '0;
			popped_codes.delete();
			errors = 0;
			codes_checked = 0;
			codes_nonzero = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (popped_codes.size() == 0) begin
					$error("key_code: unexpected item, expected none, actual %0d", key_code);
					errors++;
				end else begin
					want = popped_codes.pop_front();
					codes_checked++;
					if (want != '0)
						codes_nonzero++;
					if (key_code !== want) begin
						$error("key_code: expected %0d, actual %0d", want, key_code);
						errors++;
					end
				end
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					bdr_pkg::CFG_FILTER:     filt = cfg_data[bdr_pkg::FILTER_W-1:0];
					bdr_pkg::CFG_LONG:       long_lim = cfg_data[bdr_pkg::LONG_W-1:0];
					bdr_pkg::CFG_PERIOD:     period = cfg_data[bdr_pkg::REP_W-1:0];
					bdr_pkg::CFG_ENABLE:     rep_en = cfg_data[bdr_pkg::NUM_BTN-1:0];
					bdr_pkg::CFG_CODE_UP:    btn_code[0] = cfg_data[bdr_pkg::CODE_W-1:0];
					bdr_pkg::CFG_CODE_DOWN:  btn_code[1] = cfg_data[bdr_pkg::CODE_W-1:0];
					bdr_pkg::CFG_CODE_LEFT:  btn_code[2] = cfg_data[bdr_pkg::CODE_W-1:0];
					bdr_pkg::CFG_CODE_RIGHT: btn_code[3] = cfg_data[bdr_pkg::CODE_W-1:0];
					default: ;
				endcase
			end

			if (in_valid && !in_stall) begin
				if (kind == bdr_pkg::KIND_READ) begin
					if (rd_ptr == wr_ptr) begin
						popped_codes.push_back('0);
					end else begin
						popped_codes.push_back(key_fifo[rd_ptr]);
						rd_ptr = (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
					end
				end else begin
					deb_top = 2 * int'(filt);
					for (int b = 0; b < bdr_pkg::NUM_BTN; b++) begin
						if (pressed[b]) begin
							if (deb[b] < {1'b0, filt}) begin
								deb[b] = {1'b0, filt};
							end else if (int'(deb[b]) < deb_top) begin
								deb[b] = deb[b] + 1'b1;
							end else begin
								if (!held[b]) begin
									held[b] = 1'b1;
									push_code(btn_code[b]);
								end
								if (long_lim != '0) begin
									if (long_cnt[b] < long_lim) begin
										long_cnt[b] = long_cnt[b] + 1'b1;
									end else if (period != '0 && rep_en[b]) begin
										rep_cnt[b] = rep_cnt[b] + 1'b1;
										if (rep_cnt[b] >= period) begin
											rep_cnt[b] = '0;
											push_code(btn_code[b]);
										end
									end
								end
							end
						end else begin
							if (deb[b] > {1'b0, filt})
								deb[b] = {1'b0, filt};
							else if (deb[b] != '0)
								deb[b] = deb[b] - 1'b1;
							else
								held[b] = 1'b0;
							long_cnt[b] = '0;
							rep_cnt[b] = '0;
						end
					end
				end
			end
		end
		pending = popped_codes.size();
	end

endmodule

// File: tb/tb_button_debounce_repeat_fifo.sv
// testbench top: drives tick, read and register items into the block and reports the verdict
`timescale 1ns / 1ps
module tb_button_debounce_repeat_fifo;

	localparam int DRAIN_CYCLES = 10;
	localparam int HOLD_OFF     = 300;
	localparam int RUN_LIMIT_NS = 8_000_000;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic                         kind = bdr_pkg::KIND_TICK;
	logic [bdr_pkg::NUM_BTN-1:0]  pressed = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [bdr_pkg::CODE_W-1:0]   key_code;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [bdr_pkg::CFG_IW-1:0]   cfg_index = '0;
	logic [bdr_pkg::CFG_DW-1:0]   cfg_data = '0;

	int n_errors;
	int pending;
	int codes_checked;
	int codes_nonzero;

	int tx_pct = 0;
	int rx_pct = 0;
	int read_pct = 25;
	bit noise_on = 1'b1;
	bit hold_req = 1'b0;
	bit hold_ack = 1'b0;
	int hold_left = 0;
	int n_ticks = 0;
	int n_reads = 0;
	int n_cfg = 0;
	int n_settings = 1;

	button_debounce_repeat_fifo dut (
		.clk, .arst_n,
		.in_valid, .in_stall, .kind, .pressed,
		.out_valid, .out_stall, .key_code,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	key_code_checker #(.DEPTH(16)) u_checker (
		.clk, .arst_n,
		.in_valid, .in_stall, .kind, .pressed,
		.out_valid, .out_stall, .key_code,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.errors(n_errors), .pending(pending),
		.codes_checked(codes_checked), .codes_nonzero(codes_nonzero)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver: random stalls, or a long hold-off when requested
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_OFF;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_pct);
		end
	end

	initial begin
		#RUN_LIMIT_NS;
		$display("[button_debounce_repeat_fifo] ERROR");
		$finish;
	end

	task automatic send_item(input logic k, input logic [bdr_pkg::NUM_BTN-1:0] p);
		int gap;
		gap = ($urandom_range(99) < tx_pct) ? $urandom_range(3, 1) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		pressed <= p;
		do @(posedge clk); while (in_stall);
		if (k == bdr_pkg::KIND_READ)
			n_reads++;
		else
			n_ticks++;
	endtask

	task automatic quiesce();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input bdr_pkg::cfg_idx_t idx, input int v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v[bdr_pkg::CFG_DW-1:0];
		do @(posedge clk); while (!cfg_ready);
		n_cfg++;
	endtask

	task automatic apply_config(input int f, l, p, e, c_up, c_dn, c_lf, c_rt);
		quiesce();
		cfg_write(bdr_pkg::CFG_FILTER, f);
		cfg_write(bdr_pkg::CFG_LONG, l);
		cfg_write(bdr_pkg::CFG_PERIOD, p);
		cfg_write(bdr_pkg::CFG_ENABLE, e);
		cfg_write(bdr_pkg::CFG_CODE_UP, c_up);
		cfg_write(bdr_pkg::CFG_CODE_DOWN, c_dn);
		cfg_write(bdr_pkg::CFG_CODE_LEFT, c_lf);
		cfg_write(bdr_pkg::CFG_CODE_RIGHT, c_rt);
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	// hold a button mask, then release it, with contact bounce and reads mixed in
	task automatic key_session(input logic [bdr_pkg::NUM_BTN-1:0] mask, input int hold,
		input int rel);
		logic [bdr_pkg::NUM_BTN-1:0] lv;
		for (int i = 0; i < hold + rel; i++) begin
			lv = (i < hold) ? mask : '0;
			if (noise_on && $urandom_range(99) < 6)
				lv = lv ^ 4'($urandom_range(15, 1));
			if ($urandom_range(99) < read_pct)
				send_item(bdr_pkg::KIND_READ, 4'($urandom_range(15)));
			send_item(bdr_pkg::KIND_TICK, lv);
		end
	endtask

	task automatic run_random(input int budget, input int f, input int extra);
		int start;
		start = n_ticks + n_reads;
		while (n_ticks + n_reads - start < budget) begin
			if (noise_on && $urandom_range(99) < 15)
				repeat ($urandom_range(8, 1))
					send_item(1'($urandom_range(1)), 4'($urandom_range(15)));
			else
				key_session(4'($urandom_range(15, 1)), f + 2 + $urandom_range(extra),
					f + 2 + $urandom_range(3));
			if (n_ticks + n_reads - start > budget / 2 && $urandom_range(99) < 20)
				quiesce();
		end
		repeat (18) send_item(bdr_pkg::KIND_READ, 4'($urandom_range(15)));
		// leave all buttons held so the next register settings meet running counters
		key_session(4'hF, f + 2 + 8, 0);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_pct = 11;
		rx_pct = 54;

		// reset settings: empty read, four buttons pressed together, drain, release
		send_item(bdr_pkg::KIND_READ, 4'h0);
		repeat (7) send_item(bdr_pkg::KIND_TICK, 4'hF);
		send_item(bdr_pkg::KIND_READ, 4'hF);
		send_item(bdr_pkg::KIND_READ, 4'h0);
		send_item(bdr_pkg::KIND_READ, 4'hA);
		send_item(bdr_pkg::KIND_READ, 4'h5);
		send_item(bdr_pkg::KIND_READ, 4'hF);
		repeat (7) send_item(bdr_pkg::KIND_TICK, 4'h0);
		run_random(120, 5, 130);

		// short timings with repeat on every button, few reads: fifo wraps and overruns
		apply_config(1, 1, 1, 4'hF, $urandom_range(255, 1), $urandom_range(255, 1),
			$urandom_range(255, 1), $urandom_range(255, 1));
		read_pct = 12;
		hold_req <= !hold_req;
		run_random(60, 1, 20);

		apply_config(127, 0, 0, 0, 255, 0, 128, 1);
		read_pct = 25;
		noise_on = 1'b0;
		run_random(150, 127, 0);

		tx_pct = 54;
		rx_pct = 11;
		noise_on = 1'b1;
		apply_config(3, 1023, 255, 4'hF, $urandom_range(255), $urandom_range(255),
			$urandom_range(255), $urandom_range(255));
		run_random(40, 3, 40);

		apply_config(0, 2, 3, 4'h5, $urandom_range(255), $urandom_range(255),
			$urandom_range(255), $urandom_range(255));
		run_random(40, 0, 20);

		tx_pct = 0;
		rx_pct = 0;
		apply_config(2, 4, 200, 4'hF, $urandom_range(255, 1), $urandom_range(255, 1),
			$urandom_range(255, 1), $urandom_range(255, 1));
		run_random(40, 2, 30);

		apply_config(4, 3, 5, $urandom_range(15), $urandom_range(255), $urandom_range(255),
			$urandom_range(255), $urandom_range(255));
		run_random(40, 4, 25);

		apply_config($urandom_range(12, 1), $urandom_range(30), $urandom_range(8),
			$urandom_range(15), $urandom_range(255), $urandom_range(255),
			$urandom_range(255), $urandom_range(255));
		run_random(40, 12, 30);

		quiesce();
		$display("covered %0d ticks and %0d reads under %0d register settings (%0d writes)",
			n_ticks, n_reads, n_settings, n_cfg);
		$display("checked %0d key codes, %0d nonzero", codes_checked, codes_nonzero);
		if (n_errors == 0)
			$display("[button_debounce_repeat_fifo] OK");
		else
			$display("[button_debounce_repeat_fifo] ERROR");
		$finish;
	end

endmodule

// File: files.f
sv/bdr_pkg.sv
sv/bdr_lane.sv
sv/bdr_fifo.sv
sv/button_debounce_repeat_fifo.sv
sv/bdr_check.sv
tb/key_code_checker.sv
tb/tb_button_debounce_repeat_fifo.sv
